[hw/rtl/tss_pkg.sv]
// tag scan session controller: shared types, constants and codes
// used by tss_front, tss_back and the top level; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

   // serial receive buffer
   localparam int RX_DEPTH    = 16;
   localparam int RX_IDX_W    = $clog2(RX_DEPTH);
   localparam int FRAME_BYTES = 7;

   // short queues between input, engine and output
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_LISTEN_LIMIT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BEACON_LIMIT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SESSION_LIMIT = 2'd2;

   localparam logic [7:0]  LISTEN_LIMIT_RST  = 8'd15;
   localparam logic [7:0]  BEACON_LIMIT_RST  = 8'd6;
   localparam logic [15:0] SESSION_LIMIT_RST = 16'd430;
   localparam logic [7:0]  WINDOW_LIMIT_RST  = 8'd15;

   // event codes on the request channel
   localparam logic [2:0] MODE_SERIAL  = 3'd0;
   localparam logic [2:0] MODE_GAP     = 3'd1;
   localparam logic [2:0] MODE_WINDOW  = 3'd2;
   localparam logic [2:0] MODE_SESSION = 3'd3;
   localparam logic [2:0] MODE_RADIO   = 3'd4;

   // frame markers
   localparam logic [7:0]  CMD_HEAD   = 8'hFE;
   localparam logic [7:0]  CMD_LEN    = 8'h07;
   localparam logic [7:0]  FRAME_TAIL = 8'hFF;
   localparam logic [7:0]  TAG_HEAD   = 8'hFC;
   localparam logic [15:0] ID_NONE    = 16'hFFFF;

   typedef logic [FRAME_BYTES-1:0][7:0] frame_type;

   // byte 0 sits in the lowest lane
   localparam frame_type TIMEOUT_FRAME = {8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h07, 8'hFC};
   localparam frame_type CMD_FRAME_RST = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h07, 8'hFE};

   typedef enum logic [2:0] {
      EV_NONE,
      EV_SERIAL,
      EV_GAP,
      EV_WINDOW,
      EV_SESSION,
      EV_RADIO
   } ev_kind_type;

   typedef struct packed {
      ev_kind_type kind;
      logic        pkt_ok;   // radio header and tail look right
      frame_type   bytes;
   } event_type;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_FOUND   = 2'd1,
      KIND_TIMEOUT = 2'd2
   } frame_kind_type;

   typedef struct packed {
      frame_kind_type kind;
      frame_type      bytes;
      logic           scanning;
      logic           listening;
      logic           lamp;
   } result_type;

   // handshake between front and back
   typedef struct packed {
      logic valid;
   } evq_status_type;

   typedef struct packed {
      logic pop;
   } evq_ctrl_type;

endpackage

`default_nettype wire

[hw/rtl/tss_front.sv]
// tag scan front: decodes request words and holds them in a short event queue
// depends on tss_pkg
`timescale 1ns / 1ps
`default_nettype none

module tss_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_push,
   output logic                         req_full,
   input  wire logic [2:0]              req_mode,
   input  wire tss_pkg::frame_type      req_bytes,
   output tss_pkg::evq_status_type      evq_status,
   output tss_pkg::event_type           evq_head,
   input  wire tss_pkg::evq_ctrl_type   evq_ctrl
);

   tss_pkg::event_type slot_ff [tss_pkg::QUEUE_DEPTH];
   tss_pkg::event_type slot_in;
   logic [tss_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tss_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tss_pkg::QUEUE_CNT_W-1:0] cnt_ff, cnt_in;
   logic enq, deq;

   // classify the incoming word
   always_comb begin
      slot_in.bytes  = req_bytes;
      slot_in.pkt_ok = (req_bytes[0] == tss_pkg::TAG_HEAD) &&
                       (req_bytes[tss_pkg::FRAME_BYTES-1] == tss_pkg::FRAME_TAIL);
      unique case (req_mode)
         tss_pkg::MODE_SERIAL:  slot_in.kind = tss_pkg::EV_SERIAL;
         tss_pkg::MODE_GAP:     slot_in.kind = tss_pkg::EV_GAP;
         tss_pkg::MODE_WINDOW:  slot_in.kind = tss_pkg::EV_WINDOW;
         tss_pkg::MODE_SESSION: slot_in.kind = tss_pkg::EV_SESSION;
         tss_pkg::MODE_RADIO:   slot_in.kind = tss_pkg::EV_RADIO;
         default:               slot_in.kind = tss_pkg::EV_NONE;
      endcase
   end

   assign req_full         = (cnt_ff == tss_pkg::QUEUE_CNT_W'(tss_pkg::QUEUE_DEPTH));
   assign enq              = req_push && !req_full;
   assign deq              = evq_ctrl.pop && (cnt_ff != '0);
   assign evq_status.valid = (cnt_ff != '0);
   assign evq_head         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (enq) begin
         wr_ptr_in = (wr_ptr_ff == tss_pkg::QUEUE_PTR_W'(tss_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (deq) begin
         rd_ptr_in = (rd_ptr_ff == tss_pkg::QUEUE_PTR_W'(tss_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (enq && !deq) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (deq && !enq) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= tss_pkg::QUEUE_CNT_W'(tss_pkg::QUEUE_DEPTH))
      else $error("event queue overfilled");

   a_enq_grows: assert property (@(posedge clock) disable iff (reset)
      (enq && !deq) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("event queue lost a word");

   a_head_holds: assert property (@(posedge clock) disable iff (reset)
      (evq_status.valid && !evq_ctrl.pop) |=> (evq_head == $past(evq_head)))
      else $error("waiting event word changed");

endmodule

`default_nettype wire

[hw/rtl/tss_back.sv]
// tag scan back: session state, receive buffer, config registers and result queue
// depends on tss_pkg; fed by tss_front
`timescale 1ns / 1ps
`default_nettype none

module tss_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_write_en,
   input  wire logic [tss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tss_pkg::CSR_DATA_W-1:0] csr_data,
   input  wire tss_pkg::evq_status_type      evq_status,
   input  wire tss_pkg::event_type           evq_head,
   output tss_pkg::evq_ctrl_type             evq_ctrl,
   output logic                              rsp_empty,
   input  wire logic                         rsp_pop,
   output tss_pkg::result_type               rsp_head
);

   // configuration
   logic [7:0]  listen_lim_ff, beacon_lim_ff;
   logic [15:0] session_lim_ff;

   // session state
   logic [7:0] rx_bytes_ff [tss_pkg::RX_DEPTH];
   logic [tss_pkg::RX_IDX_W-1:0] rx_count_ff, rx_count_in;
   logic gap_armed_ff, gap_armed_in;
   tss_pkg::frame_type cmd_frame_ff, cmd_frame_in;
   logic [15:0] target_id_ff, target_id_in;
   logic scan_on_ff, scan_on_in;
   logic listen_on_ff, listen_on_in;
   logic lamp_ff, lamp_in;
   logic [7:0] win_cnt_ff, win_cnt_in;
   logic [7:0] win_lim_ff, win_lim_in;
   logic [15:0] sess_cnt_ff, sess_cnt_in;
   logic rx_wr;

   // result queue
   tss_pkg::result_type out_slot_ff [tss_pkg::QUEUE_DEPTH];
   tss_pkg::result_type out_slot_in;
   logic [tss_pkg::QUEUE_PTR_W-1:0] out_wr_ff, out_wr_in;
   logic [tss_pkg::QUEUE_PTR_W-1:0] out_rd_ff, out_rd_in;
   logic [tss_pkg::QUEUE_CNT_W-1:0] out_cnt_ff, out_cnt_in;
   logic out_full, consume, deq;

   tss_pkg::frame_type rx_frame;
   tss_pkg::frame_kind_type kind;
   logic [15:0] pkt_id;

   assign out_full     = (out_cnt_ff == tss_pkg::QUEUE_CNT_W'(tss_pkg::QUEUE_DEPTH));
   assign deq          = rsp_pop && !rsp_empty;
   assign consume      = evq_status.valid && (!out_full || deq);
   assign evq_ctrl.pop = consume;
   assign rsp_empty    = (out_cnt_ff == '0);
   assign rsp_head     = out_slot_ff[out_rd_ff];
   assign pkt_id       = {evq_head.bytes[4], evq_head.bytes[5]};

   always_comb begin
      for (int i = 0; i < tss_pkg::FRAME_BYTES; i++) begin
         rx_frame[i] = rx_bytes_ff[i];
      end
   end

   // one event per cycle, unless the result queue is full and not popped
   always_comb begin
      rx_count_in  = rx_count_ff;
      gap_armed_in = gap_armed_ff;
      cmd_frame_in = cmd_frame_ff;
      target_id_in = target_id_ff;
      scan_on_in   = scan_on_ff;
      listen_on_in = listen_on_ff;
      lamp_in      = lamp_ff;
      win_cnt_in   = win_cnt_ff;
      win_lim_in   = win_lim_ff;
      sess_cnt_in  = sess_cnt_ff;
      rx_wr        = 1'b0;
      kind         = tss_pkg::KIND_NONE;
      if (consume) begin
         case (evq_head.kind)
            tss_pkg::EV_SERIAL: begin
               rx_wr        = 1'b1;
               rx_count_in  = (rx_count_ff == tss_pkg::RX_IDX_W'(tss_pkg::RX_DEPTH - 1)) ?
                              '0 : rx_count_ff + 1'b1;
               gap_armed_in = 1'b1;
            end
            tss_pkg::EV_GAP: begin
               if (gap_armed_ff) begin
                  gap_armed_in = 1'b0;
                  rx_count_in  = '0;
                  if (rx_count_ff == tss_pkg::RX_IDX_W'(tss_pkg::FRAME_BYTES)) begin
                     cmd_frame_in = rx_frame;
                     target_id_in = {rx_frame[4], rx_frame[5]};
                     if (rx_frame[0] == tss_pkg::CMD_HEAD &&
                         rx_frame[1] == tss_pkg::CMD_LEN &&
                         rx_frame[tss_pkg::FRAME_BYTES-1] == tss_pkg::FRAME_TAIL &&
                         target_id_in != tss_pkg::ID_NONE) begin
                        scan_on_in = 1'b1;
                     end
                  end
               end
            end
            tss_pkg::EV_WINDOW: begin
               if (scan_on_ff) begin
                  if (win_cnt_ff > win_lim_ff) begin
                     win_cnt_in   = '0;
                     win_lim_in   = listen_on_ff ? beacon_lim_ff : listen_lim_ff;
                     listen_on_in = !listen_on_ff;
                     lamp_in      = !lamp_ff;
                  end else begin
                     win_cnt_in = win_cnt_ff + 1'b1;
                  end
               end
            end
            tss_pkg::EV_SESSION: begin
               if (scan_on_ff) begin
                  if (sess_cnt_ff > session_lim_ff) begin
                     scan_on_in   = 1'b0;
                     listen_on_in = 1'b0;
                     lamp_in      = 1'b0;
                     sess_cnt_in  = '0;
                     kind         = tss_pkg::KIND_TIMEOUT;
                  end else begin
                     sess_cnt_in = sess_cnt_ff + 1'b1;
                  end
               end
            end
            tss_pkg::EV_RADIO: begin
               if (scan_on_ff && listen_on_ff && evq_head.pkt_ok && pkt_id == target_id_ff) begin
                  scan_on_in   = 1'b0;
                  listen_on_in = 1'b0;
                  lamp_in      = 1'b0;
                  sess_cnt_in  = '0;
                  kind         = tss_pkg::KIND_FOUND;
               end
            end
            default: begin
            end
         endcase
      end

      out_slot_in.kind      = kind;
      out_slot_in.scanning  = scan_on_in;
      out_slot_in.listening = listen_on_in;
      out_slot_in.lamp      = lamp_in;
      case (kind)
         tss_pkg::KIND_FOUND:   out_slot_in.bytes = evq_head.bytes;
         tss_pkg::KIND_TIMEOUT: out_slot_in.bytes = tss_pkg::TIMEOUT_FRAME;
         default:               out_slot_in.bytes = cmd_frame_in;
      endcase
   end

   // result queue pointers
   always_comb begin
      out_wr_in  = out_wr_ff;
      out_rd_in  = out_rd_ff;
      out_cnt_in = out_cnt_ff;
      if (consume) begin
         out_wr_in = (out_wr_ff == tss_pkg::QUEUE_PTR_W'(tss_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : out_wr_ff + 1'b1;
      end
      if (deq) begin
         out_rd_in = (out_rd_ff == tss_pkg::QUEUE_PTR_W'(tss_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : out_rd_ff + 1'b1;
      end
      if (consume && !deq) begin
         out_cnt_in = out_cnt_ff + 1'b1;
      end else if (deq && !consume) begin
         out_cnt_in = out_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rx_wr) begin
         rx_bytes_ff[rx_count_ff] <= evq_head.bytes[0];
      end
      if (consume) begin
         out_slot_ff[out_wr_ff] <= out_slot_in;
      end
      if (reset) begin
         listen_lim_ff  <= tss_pkg::LISTEN_LIMIT_RST;
         beacon_lim_ff  <= tss_pkg::BEACON_LIMIT_RST;
         session_lim_ff <= tss_pkg::SESSION_LIMIT_RST;
         rx_count_ff    <= '0;
         gap_armed_ff   <= 1'b0;
         cmd_frame_ff   <= tss_pkg::CMD_FRAME_RST;
         target_id_ff   <= '0;
         scan_on_ff     <= 1'b0;
         listen_on_ff   <= 1'b0;
         lamp_ff        <= 1'b0;
         win_cnt_ff     <= '0;
         win_lim_ff     <= tss_pkg::WINDOW_LIMIT_RST;
         sess_cnt_ff    <= '0;
         out_wr_ff      <= '0;
         out_rd_ff      <= '0;
         out_cnt_ff     <= '0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               tss_pkg::CSR_LISTEN_LIMIT:  listen_lim_ff  <= csr_data[7:0];
               tss_pkg::CSR_BEACON_LIMIT:  beacon_lim_ff  <= csr_data[7:0];
               tss_pkg::CSR_SESSION_LIMIT: session_lim_ff <= csr_data;
               default: begin
               end
            endcase
         end
         rx_count_ff  <= rx_count_in;
         gap_armed_ff <= gap_armed_in;
         cmd_frame_ff <= cmd_frame_in;
         target_id_ff <= target_id_in;
         scan_on_ff   <= scan_on_in;
         listen_on_ff <= listen_on_in;
         lamp_ff      <= lamp_in;
         win_cnt_ff   <= win_cnt_in;
         win_lim_ff   <= win_lim_in;
         sess_cnt_ff  <= sess_cnt_in;
         out_wr_ff    <= out_wr_in;
         out_rd_ff    <= out_rd_in;
         out_cnt_ff   <= out_cnt_in;
      end
   end

   a_listen_in_scan: assert property (@(posedge clock) disable iff (reset)
      listen_on_ff |-> scan_on_ff)
      else $error("listen window outside a scan");

   a_lamp_tracks: assert property (@(posedge clock) disable iff (reset)
      lamp_ff == listen_on_ff)
      else $error("lamp out of step with window");

   a_out_bound: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= tss_pkg::QUEUE_CNT_W'(tss_pkg::QUEUE_DEPTH))
      else $error("result queue overfilled");

   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      (consume && kind != tss_pkg::KIND_NONE) |=> (!scan_on_ff && sess_cnt_ff == '0))
      else $error("scan still running after a host frame");

endmodule

`default_nettype wire

[hw/rtl/tag_scan_session_controller_unit.sv]
// tag scan session controller top level: request and result queues, config port
// depends on tss_pkg, tss_front and tss_back
`timescale 1ns / 1ps
`default_nettype none

// usage
//   request side: a word is taken at a clock edge with req_push high and req_full
//   low; req_mode picks serial byte, gap timeout, window tick, session tick or
//   radio packet, req_byte0..req_byte6 carry the byte or the packet
//   result side: every request word gives exactly one result word, in order;
//   it stands on the rsp_ ports while rsp_empty is low and leaves at an edge
//   with rsp_pop high
//   config: csr_write_en with csr_index 0 listen limit, 1 beacon limit,
//   2 session limit; write only while the block is idle
// timing
//   one word per cycle sustained unless the result side stalls; an accepted
//   word waits in the event queue, is consumed from there by the session
//   engine, and its result is registered into the result queue, where it
//   drops rsp_empty and can be popped
//   the throughput is set by the state update in the back end
// stalls
//   a two-word event queue sits between decode and the engine and a two-word
//   result queue after it; with rsp_pop held low up to four words are taken
//   before req_full rises
// reset
//   synchronous; clears both queues and the session state, command frame back
//   to FE 07 FF FF FF FF FF and the limits back to 15, 6 and 430

module tag_scan_session_controller_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_push,
   output logic                                  req_full,
   input  wire logic [2:0]                       req_mode,
   input  wire logic [7:0]                       req_byte0,
   input  wire logic [7:0]                       req_byte1,
   input  wire logic [7:0]                       req_byte2,
   input  wire logic [7:0]                       req_byte3,
   input  wire logic [7:0]                       req_byte4,
   input  wire logic [7:0]                       req_byte5,
   input  wire logic [7:0]                       req_byte6,
   output logic                                  rsp_empty,
   input  wire logic                             rsp_pop,
   output logic [1:0]                            rsp_frame_kind,
   output logic [7:0]                            rsp_out0,
   output logic [7:0]                            rsp_out1,
   output logic [7:0]                            rsp_out2,
   output logic [7:0]                            rsp_out3,
   output logic [7:0]                            rsp_out4,
   output logic [7:0]                            rsp_out5,
   output logic [7:0]                            rsp_out6,
   output logic                                  rsp_scanning,
   output logic                                  rsp_listening,
   output logic                                  rsp_lamp,
   input  wire logic                             csr_write_en,
   input  wire logic [tss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tss_pkg::CSR_DATA_W-1:0]   csr_data
);

   tss_pkg::frame_type      req_bytes;
   tss_pkg::evq_status_type evq_status;
   tss_pkg::event_type      evq_head;
   tss_pkg::evq_ctrl_type   evq_ctrl;
   tss_pkg::result_type     rsp_head;

   // byte 0 in the lowest lane
   assign req_bytes = {req_byte6, req_byte5, req_byte4, req_byte3,
                       req_byte2, req_byte1, req_byte0};

   // decode and event queue
   tss_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_mode   (req_mode),
      .req_bytes  (req_bytes),
      .evq_status (evq_status),
      .evq_head   (evq_head),
      .evq_ctrl   (evq_ctrl)
   );

   // session engine and result queue
   tss_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .evq_status   (evq_status),
      .evq_head     (evq_head),
      .evq_ctrl     (evq_ctrl),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_head     (rsp_head)
   );

   // unpack the oldest result word
   assign rsp_frame_kind = rsp_head.kind;
   assign rsp_out0       = rsp_head.bytes[0];
   assign rsp_out1       = rsp_head.bytes[1];
   assign rsp_out2       = rsp_head.bytes[2];
   assign rsp_out3       = rsp_head.bytes[3];
   assign rsp_out4       = rsp_head.bytes[4];
   assign rsp_out5       = rsp_head.bytes[5];
   assign rsp_out6       = rsp_head.bytes[6];
   assign rsp_scanning   = rsp_head.scanning;
   assign rsp_listening  = rsp_head.listening;
   assign rsp_lamp       = rsp_head.lamp;

endmodule

`default_nettype wire

[tb/tss_scan_checker.sv]
// scoreboard for the tag scan session controller: watches the request, result and
// register ports, keeps its own copy of the session state and checks every result word
// depends on tss_pkg only
`timescale 1ns / 1ps

module tss_scan_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   input  wire logic                           req_full,
   input  wire logic [2:0]                     req_mode,
   input  wire logic [7:0]                     req_byte0,
   input  wire logic [7:0]                     req_byte1,
   input  wire logic [7:0]                     req_byte2,
   input  wire logic [7:0]                     req_byte3,
   input  wire logic [7:0]                     req_byte4,
   input  wire logic [7:0]                     req_byte5,
   input  wire logic [7:0]                     req_byte6,
   input  wire logic                           rsp_empty,
   input  wire logic                           rsp_pop,
   input  wire logic [1:0]                     rsp_frame_kind,
   input  wire logic [7:0]                     rsp_out0,
   input  wire logic [7:0]                     rsp_out1,
   input  wire logic [7:0]                     rsp_out2,
   input  wire logic [7:0]                     rsp_out3,
   input  wire logic [7:0]                     rsp_out4,
   input  wire logic [7:0]                     rsp_out5,
   input  wire logic [7:0]                     rsp_out6,
   input  wire logic                           rsp_scanning,
   input  wire logic                           rsp_listening,
   input  wire logic                           rsp_lamp,
   input  wire logic                           csr_write_en,
   input  wire logic [tss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tss_pkg::CSR_DATA_W-1:0] csr_data,
   output int                                  mismatch_count,
   output int                                  words_pending
);

   // shadow session state
   logic [7:0]          rx_buf [tss_pkg::RX_DEPTH];
   int                  rx_fill;
   logic                rx_armed;
   tss_pkg::frame_type  cmd_frame;
   logic [15:0]         target_tag;
   logic                scan_active;
   logic                in_listen;
   logic                lamp_on;
   logic [7:0]          win_count;
   logic [7:0]          win_limit;
   logic [15:0]         session_ticks;

   // shadow registers
   logic [7:0]  lim_listen;
   logic [7:0]  lim_beacon;
   logic [15:0] lim_session;

   tss_pkg::result_type frames_due [$];

   initial begin
      mismatch_count = 0;
      words_pending  = 0;
   end

   task automatic end_scan();
      scan_active   = 1'b0;
      in_listen     = 1'b0;
      lamp_on       = 1'b0;
      session_ticks = 16'd0;
   endtask

   task automatic predict_frame(input logic [2:0] mode, input tss_pkg::frame_type pkt);
      tss_pkg::result_type r;
      logic [7:0]          old_win;
      logic [15:0]         old_sess;
      int                  i;
      r.kind = tss_pkg::KIND_NONE;
      case (mode)
         tss_pkg::MODE_SERIAL: begin
            rx_buf[rx_fill] = pkt[0];
            rx_fill = (rx_fill + 1) % tss_pkg::RX_DEPTH;
            rx_armed = 1'b1;
         end
         tss_pkg::MODE_GAP: if (rx_armed) begin
            rx_armed = 1'b0;
            if (rx_fill == tss_pkg::FRAME_BYTES) begin
               for (i = 0; i < tss_pkg::FRAME_BYTES; i++) cmd_frame[i] = rx_buf[i];
               target_tag = {cmd_frame[4], cmd_frame[5]};
               if (cmd_frame[0] == tss_pkg::CMD_HEAD && cmd_frame[1] == tss_pkg::CMD_LEN &&
                   cmd_frame[6] == tss_pkg::FRAME_TAIL && target_tag != tss_pkg::ID_NONE)
                  scan_active = 1'b1;
            end
            rx_fill = 0;
         end
         tss_pkg::MODE_WINDOW: if (scan_active) begin
            old_win = win_count;
            win_count = win_count + 8'd1;
            if (old_win > win_limit) begin
               win_count = 8'd0;
               win_limit = in_listen ? lim_beacon : lim_listen;
               in_listen = !in_listen;
               lamp_on   = !lamp_on;
            end
         end
         tss_pkg::MODE_SESSION: if (scan_active) begin
            old_sess = session_ticks;
            session_ticks = session_ticks + 16'd1;
            if (old_sess > lim_session) begin
               end_scan();
               r.kind = tss_pkg::KIND_TIMEOUT;
            end
         end
         tss_pkg::MODE_RADIO: begin
            if (scan_active && in_listen && pkt[0] == tss_pkg::TAG_HEAD &&
                pkt[6] == tss_pkg::FRAME_TAIL && {pkt[4], pkt[5]} == target_tag) begin
               end_scan();
               r.kind = tss_pkg::KIND_FOUND;
            end
         end
         default: ;
      endcase
      case (r.kind)
         tss_pkg::KIND_FOUND:   r.bytes = pkt;
         tss_pkg::KIND_TIMEOUT: r.bytes = tss_pkg::TIMEOUT_FRAME;
         default:               r.bytes = cmd_frame;
      endcase
      r.scanning  = scan_active;
      r.listening = in_listen;
      r.lamp      = lamp_on;
      frames_due.push_back(r);
   endtask

   task automatic check_word();
      tss_pkg::result_type want;
      tss_pkg::frame_type  got;
      int                  i;
      bit                  bad;
      got = {rsp_out6, rsp_out5, rsp_out4, rsp_out3, rsp_out2, rsp_out1, rsp_out0};
      if (frames_due.size() == 0) begin
         $error("result word with no request waiting for it");
         mismatch_count++;
      end else begin
         want = frames_due.pop_front();
         bad = 1'b0;
         if (rsp_frame_kind !== want.kind) begin
            $error("frame_kind: expected %0d, got %0d", want.kind, rsp_frame_kind);
            bad = 1'b1;
         end
         for (i = 0; i < tss_pkg::FRAME_BYTES; i++) begin
            if (got[i] !== want.bytes[i]) begin
               $error("out%0d: expected %02h, got %02h", i, want.bytes[i], got[i]);
               bad = 1'b1;
            end
         end
         if (rsp_scanning !== want.scanning) begin
            $error("scanning: expected %0b, got %0b", want.scanning, rsp_scanning);
            bad = 1'b1;
         end
         if (rsp_listening !== want.listening) begin
            $error("listening: expected %0b, got %0b", want.listening, rsp_listening);
            bad = 1'b1;
         end
         if (rsp_lamp !== want.lamp) begin
            $error("lamp: expected %0b, got %0b", want.lamp, rsp_lamp);
            bad = 1'b1;
         end
         if (bad) mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tss_pkg::RX_DEPTH; i++) rx_buf[i] = 8'd0;
         rx_fill       = 0;
         rx_armed      = 1'b0;
         cmd_frame     = tss_pkg::CMD_FRAME_RST;
         target_tag    = 16'd0;
         scan_active   = 1'b0;
         in_listen     = 1'b0;
         lamp_on       = 1'b0;
         win_count     = 8'd0;
         win_limit     = tss_pkg::WINDOW_LIMIT_RST;
         session_ticks = 16'd0;
         lim_listen    = tss_pkg::LISTEN_LIMIT_RST;
         lim_beacon    = tss_pkg::BEACON_LIMIT_RST;
         lim_session   = tss_pkg::SESSION_LIMIT_RST;
         frames_due.delete();
      end else begin
         // results first, so a word can never be matched against its own request
         if (rsp_pop && !rsp_empty) check_word();
         if (csr_write_en) begin
            case (csr_index)
               tss_pkg::CSR_LISTEN_LIMIT:  lim_listen  = csr_data[7:0];
               tss_pkg::CSR_BEACON_LIMIT:  lim_beacon  = csr_data[7:0];
               tss_pkg::CSR_SESSION_LIMIT: lim_session = csr_data[15:0];
               default: ;
            endcase
         end
         if (req_push && !req_full)
            predict_frame(req_mode, {req_byte6, req_byte5, req_byte4, req_byte3,
                                     req_byte2, req_byte1, req_byte0});
      end
      words_pending = frames_due.size();
   end

endmodule

[tb/tb_tag_scan_session_controller_unit.sv]
// top of the tag scan session controller bench: clock, reset, request stimulus,
// result back-pressure and the verdict; depends on tss_pkg, the block and tss_scan_checker
`timescale 1ns / 1ps

module tb_tag_scan_session_controller_unit;

   // mode codes the block must ignore
   localparam logic [2:0]                    MODE_SPARE_FIRST = 3'd5;
   // register index with nothing behind it
   localparam logic [tss_pkg::CSR_IDX_W-1:0] CSR_SPARE        = 2'd3;

   localparam int PHASES      = 5;
   localparam int PHASE_WORDS = 260;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_push = 1'b0;
   logic                           req_full;
   logic [2:0]                     req_mode = tss_pkg::MODE_SERIAL;
   logic [7:0]                     req_byte0 = 8'd0;
   logic [7:0]                     req_byte1 = 8'd0;
   logic [7:0]                     req_byte2 = 8'd0;
   logic [7:0]                     req_byte3 = 8'd0;
   logic [7:0]                     req_byte4 = 8'd0;
   logic [7:0]                     req_byte5 = 8'd0;
   logic [7:0]                     req_byte6 = 8'd0;
   logic                           rsp_empty;
   logic                           rsp_pop = 1'b0;
   logic [1:0]                     rsp_frame_kind;
   logic [7:0]                     rsp_out0, rsp_out1, rsp_out2, rsp_out3;
   logic [7:0]                     rsp_out4, rsp_out5, rsp_out6;
   logic                           rsp_scanning;
   logic                           rsp_listening;
   logic                           rsp_lamp;
   logic                           csr_write_en = 1'b0;
   logic [tss_pkg::CSR_IDX_W-1:0]  csr_index = tss_pkg::CSR_LISTEN_LIMIT;
   logic [tss_pkg::CSR_DATA_W-1:0] csr_data = '0;

   int mismatch_count;
   int words_pending;

   // sender bookkeeping
   int          words_sent = 0;
   int          burst_left = 0;
   logic [15:0] cur_tag = 16'd0;   // tag id of the last command frame sent

   // receiver stall pattern
   int pattern_sel  = 0;
   int pattern_left = 0;

   tag_scan_session_controller_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_mode       (req_mode),
      .req_byte0      (req_byte0),
      .req_byte1      (req_byte1),
      .req_byte2      (req_byte2),
      .req_byte3      (req_byte3),
      .req_byte4      (req_byte4),
      .req_byte5      (req_byte5),
      .req_byte6      (req_byte6),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_frame_kind (rsp_frame_kind),
      .rsp_out0       (rsp_out0),
      .rsp_out1       (rsp_out1),
      .rsp_out2       (rsp_out2),
      .rsp_out3       (rsp_out3),
      .rsp_out4       (rsp_out4),
      .rsp_out5       (rsp_out5),
      .rsp_out6       (rsp_out6),
      .rsp_scanning   (rsp_scanning),
      .rsp_listening  (rsp_listening),
      .rsp_lamp       (rsp_lamp),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   tss_scan_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_mode       (req_mode),
      .req_byte0      (req_byte0),
      .req_byte1      (req_byte1),
      .req_byte2      (req_byte2),
      .req_byte3      (req_byte3),
      .req_byte4      (req_byte4),
      .req_byte5      (req_byte5),
      .req_byte6      (req_byte6),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_frame_kind (rsp_frame_kind),
      .rsp_out0       (rsp_out0),
      .rsp_out1       (rsp_out1),
      .rsp_out2       (rsp_out2),
      .rsp_out3       (rsp_out3),
      .rsp_out4       (rsp_out4),
      .rsp_out5       (rsp_out5),
      .rsp_out6       (rsp_out6),
      .rsp_scanning   (rsp_scanning),
      .rsp_listening  (rsp_listening),
      .rsp_lamp       (rsp_lamp),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   // 100 MHz
   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   // result side back-pressure: each pattern holds for a random stretch;
   // always ready, coin toss, or mostly stalled
   always @(negedge clock) begin
      if (pattern_left == 0) begin
         pattern_sel  <= $urandom_range(0, 2);
         pattern_left <= $urandom_range(32, 200);
      end else begin
         pattern_left <= pattern_left - 1;
      end
      case (pattern_sel)
         0:       rsp_pop <= 1'b1;
         1:       rsp_pop <= 1'($urandom_range(0, 1));
         default: rsp_pop <= ($urandom_range(0, 7) == 0);
      endcase
   end

   function automatic tss_pkg::frame_type rand_frame();
      tss_pkg::frame_type f;
      int                 i;
      for (i = 0; i < tss_pkg::FRAME_BYTES; i++) f[i] = 8'($urandom_range(0, 255));
      return f;
   endfunction

   // one request word; the sender runs in bursts with idle gaps between them.
   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_word(input logic [2:0] mode, input tss_pkg::frame_type pkt);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         // now and then a burst follows straight on, no gap
         if ($urandom_range(0, 3) != 0) begin
            req_push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
      burst_left--;
      req_push  <= 1'b1;
      req_mode  <= mode;
      req_byte0 <= pkt[0];
      req_byte1 <= pkt[1];
      req_byte2 <= pkt[2];
      req_byte3 <= pkt[3];
      req_byte4 <= pkt[4];
      req_byte5 <= pkt[5];
      req_byte6 <= pkt[6];
      @(posedge clock);
      while (req_full) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   // serial byte, with junk in the unused lanes
   task automatic send_serial(input logic [7:0] value);
      tss_pkg::frame_type f;
      f = rand_frame();
      f[0] = value;
      send_word(tss_pkg::MODE_SERIAL, f);
   endtask

   // first n bytes of a frame over the serial link, wrapping round the frame
   task automatic send_frame(input tss_pkg::frame_type f, input int n);
      int k;
      for (k = 0; k < n; k++) send_serial(f[k % tss_pkg::FRAME_BYTES]);
   endtask

   // host command: mostly a well formed FE 07 .. id .. FF frame framed by gap
   // timeouts, sometimes with a damaged byte, a wrong length or no closing gap
   task automatic send_command();
      tss_pkg::frame_type f;
      logic [15:0]        tag;
      int                 pick;
      int                 n;
      pick = $urandom_range(0, 99);
      if (pick < 5)       tag = tss_pkg::ID_NONE;
      else if (pick < 12) tag = 16'h0000;
      else                tag = 16'($urandom_range(0, 65535));
      f = rand_frame();
      f[0] = tss_pkg::CMD_HEAD;
      f[1] = tss_pkg::CMD_LEN;
      f[4] = tag[15:8];
      f[5] = tag[7:0];
      f[6] = tss_pkg::FRAME_TAIL;
      if ($urandom_range(0, 9) == 0) f[$urandom_range(0, 6)] = 8'($urandom_range(0, 255));
      n = ($urandom_range(0, 9) < 8) ? tss_pkg::FRAME_BYTES : $urandom_range(5, 9);
      // a leading gap clears whatever partial count is left in the buffer
      if ($urandom_range(0, 4) != 0) send_word(tss_pkg::MODE_GAP, rand_frame());
      send_frame(f, n);
      if ($urandom_range(0, 19) != 0) send_word(tss_pkg::MODE_GAP, rand_frame());
      cur_tag = tag;
   endtask

   // radio packet: mostly FC .. tag .. FF for the current target, some damaged,
   // some pure noise
   task automatic send_radio();
      tss_pkg::frame_type f;
      int                 lane;
      f = rand_frame();
      if ($urandom_range(0, 9) < 7) begin
         f[0] = tss_pkg::TAG_HEAD;
         f[4] = cur_tag[15:8];
         f[5] = cur_tag[7:0];
         f[6] = tss_pkg::FRAME_TAIL;
         if ($urandom_range(0, 6) == 0) begin
            lane = $urandom_range(0, 3);
            f[(lane == 0) ? 0 : lane + 3] = 8'($urandom_range(0, 255));
         end
      end
      send_word(tss_pkg::MODE_RADIO, f);
   endtask

   task automatic random_event();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         send_command();
      end else if (pick < 45) begin
         repeat ($urandom_range(1, 20)) send_word(tss_pkg::MODE_WINDOW, rand_frame());
      end else if (pick < 60) begin
         // mostly short runs of session ticks, now and then a long one
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 60)) send_word(tss_pkg::MODE_SESSION, rand_frame());
         else
            repeat ($urandom_range(1, 10)) send_word(tss_pkg::MODE_SESSION, rand_frame());
      end else if (pick < 80) begin
         send_radio();
      end else if (pick < 90) begin
         // serial noise, long enough at times to wrap the receive count
         repeat ($urandom_range(1, 20)) send_serial(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 1) == 0) send_word(tss_pkg::MODE_GAP, rand_frame());
      end else begin
         send_word(3'($urandom_range(0, 7)), rand_frame());
      end
   endtask

   // stop sending and wait until every result word has come back
   task automatic drain();
      req_push <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (words_pending != 0);
   endtask

   // all registers in back-to-back writes, upper data bits of the 8-bit limits filled
   // with junk, plus a write to the empty index
   task automatic program_limits(input logic [7:0] listen, input logic [7:0] beacon,
                                 input logic [15:0] session);
      csr_write_en <= 1'b1;
      csr_index    <= tss_pkg::CSR_LISTEN_LIMIT;
      csr_data     <= {8'($urandom_range(0, 255)), listen};
      @(negedge clock);
      csr_index    <= tss_pkg::CSR_BEACON_LIMIT;
      csr_data     <= {8'($urandom_range(0, 255)), beacon};
      @(negedge clock);
      csr_index    <= tss_pkg::CSR_SESSION_LIMIT;
      csr_data     <= session;
      @(negedge clock);
      csr_index    <= CSR_SPARE;
      csr_data     <= 16'($urandom_range(0, 65535));
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   initial begin : stimulus
      int k;
      int phase;
      int goal;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: events with no scan running, gap with nothing armed,
      // the unused mode codes, then a scan start with id 0000
      send_word(tss_pkg::MODE_GAP, rand_frame());
      send_word(tss_pkg::MODE_WINDOW, rand_frame());
      send_word(tss_pkg::MODE_SESSION, rand_frame());
      send_word(tss_pkg::MODE_RADIO, {7{8'hFF}});
      for (k = 0; k < 3; k++)
         send_word(MODE_SPARE_FIRST + k[2:0],
                   (k == 0) ? {7{8'h00}} : ((k == 1) ? {7{8'hFF}} : rand_frame()));
      send_frame({tss_pkg::FRAME_TAIL, 8'h00, 8'h00, 8'hFF, 8'h00,
                  tss_pkg::CMD_LEN, tss_pkg::CMD_HEAD}, tss_pkg::FRAME_BYTES);
      send_word(tss_pkg::MODE_GAP, rand_frame());
      send_word(tss_pkg::MODE_WINDOW, rand_frame());
      // matching tag packet during a beacon window: must be ignored
      send_word(tss_pkg::MODE_RADIO, {tss_pkg::FRAME_TAIL, 8'h00, 8'h00, 8'h5A, 8'hA5,
                                      8'h00, tss_pkg::TAG_HEAD});
      // a well framed command with id FFFF during a scan: target changes, scan goes on
      send_frame({tss_pkg::FRAME_TAIL, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                  tss_pkg::CMD_LEN, tss_pkg::CMD_HEAD}, tss_pkg::FRAME_BYTES);
      send_word(tss_pkg::MODE_GAP, rand_frame());

      // random phases, each under its own register setting; phase 0 keeps
      // the reset values, the others cover zero, full scale and small limits
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            drain();
            case (phase)
               1:       program_limits(8'd0, 8'd0, 16'd0);
               2:       program_limits(8'd255, 8'd255, 16'd65535);
               3:       program_limits(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                                       16'($urandom_range(3, 60)));
               default: program_limits(8'd2, 8'd1, 16'd400);
            endcase
         end
         goal = words_sent + PHASE_WORDS;
         while (words_sent < goal) random_event();
      end

      drain();
      // keep the clock running so a stray late word would still be caught
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && words_pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
